/* design/md5sh_pkg.sv */
package md5sh_pkg;

  // working and chaining words of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5sh_words_t;

  // request modes
  localparam logic ModeAbsorb = 1'b0;
  localparam logic ModeFinish = 1'b1;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam md5sh_words_t InitChain = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  // per-round additive constants
  localparam logic [31:0] SineK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // left rotate amounts, indexed by {round group, round mod 4}
  localparam logic [4:0] RotAmt [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = lo + {lo[1:0], 2'b00} + 4'd1;
      2'd2:    idx = lo + {lo[2:0], 1'b0} + 4'd5;
      default: idx = {lo[0], 3'b000} - lo;
    endcase
    return idx;
  endfunction

endpackage

/* design/md5sh_if.sv */
// byte and finish requests into the hash
interface md5sh_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// digest words out of the hash
interface md5sh_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

/* design/md5sh_ram.sv */
module md5sh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/md5sh_round.sv */
module md5sh_round (
  input  logic [5:0]                rnd_i,
  input  md5sh_pkg::md5sh_words_t   words_i,
  input  logic [31:0]               msg_i,
  output md5sh_pkg::md5sh_words_t   words_o
);
  import md5sh_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  amt;
  logic [63:0] dbl;

  // round function by group
  always_comb begin
    unique case (rnd_i[5:4])
      2'd0:    f = (words_i.b & words_i.c) | (~words_i.b & words_i.d);
      2'd1:    f = (words_i.d & words_i.b) | (~words_i.d & words_i.c);
      2'd2:    f = words_i.b ^ words_i.c ^ words_i.d;
      default: f = words_i.c ^ (words_i.b | ~words_i.d);
    endcase
  end

  // add, rotate, add to b, rotate words
  assign sum = f + words_i.a + SineK[rnd_i] + msg_i;
  assign amt = RotAmt[{rnd_i[5:4], rnd_i[1:0]}];
  assign dbl = {sum, sum} << amt;

  assign words_o.a = words_i.d;
  assign words_o.b = words_i.b + dbl[63:32];
  assign words_o.c = words_i.b;
  assign words_o.d = words_i.c;

endmodule

/* design/md5_stream_hash_top.sv */
// channel   dir  handshake      payload
// req_i     in   valid/ready    mode, data_byte
// dig_o     out  valid/ready    digest_word, word_index, last
//
// an absorb request is accepted in idle; the one that completes a 64-byte block
// also runs the compression, one round per cycle (load, 64 rounds, add), before the next request
// a finish request with f bytes held pads them out to a full block and compresses it,
// then pads and compresses one more block when f >= 56; then it hands off the digest
// the four digest words sit in an output buffer, so new requests go on while
// they drain; a later finish waits for the buffer to empty
// reset is asynchronous and returns the initial chaining state; no clearing pass
module md5_stream_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5sh_req_if.sink   req_i,
  md5sh_dig_if.source dig_o
);
  import md5sh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [5:0]       fill_q, fill_d;
  logic [63:0]      bitlen_q, bitlen_d;
  md5sh_words_t     chain_q, chain_d;
  md5sh_words_t     rw_q, rw_d;
  logic [5:0]       rnd_q, rnd_d;
  logic             first_q, first_d;
  logic             lenblk_q, lenblk_d;
  logic             fin_q, fin_d;
  logic [3:0][31:0] obuf_q, obuf_d;
  logic [1:0]       oidx_q, oidx_d;
  logic             obusy_q, obusy_d;

  logic             req_acc;
  logic             mem_we;
  logic [7:0]       mem_wdata;
  logic [3:0]       mem_raddr;
  logic [31:0]      mem_rdata;
  logic [7:0]       pad_byte;
  md5sh_words_t     round_nxt;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // block buffer, one lane per byte of a message word
  for (genvar lane = 0; lane < 4; lane++) begin : g_lane
    md5sh_ram #(
      .Width(8),
      .Depth(BlockBytes / 4)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (mem_we && (fill_q[1:0] == 2'(lane))),
      .waddr_i(fill_q[5:2]),
      .wdata_i(mem_wdata),
      .raddr_i(mem_raddr),
      .rdata_o(mem_rdata[8*lane +: 8])
    );
  end

  // shared round unit
  md5sh_round u_round (
    .rnd_i  (rnd_q),
    .words_i(rw_q),
    .msg_i  (mem_rdata),
    .words_o(round_nxt)
  );

  // padding byte for the current fill position
  always_comb begin
    if (first_q) begin
      pad_byte = PadByte;
    end else if (lenblk_q && (fill_q >= 6'(LenPos))) begin
      pad_byte = bitlen_q[{fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bitlen_d  = bitlen_q;
    chain_d   = chain_q;
    rw_d      = rw_q;
    rnd_d     = rnd_q;
    first_d   = first_q;
    lenblk_d  = lenblk_q;
    fin_d     = fin_q;
    obuf_d    = obuf_q;
    oidx_d    = oidx_q;
    obusy_d   = obusy_q;
    mem_we    = 1'b0;
    mem_wdata = req_i.data_byte;
    mem_raddr = msg_index(rnd_q + 6'd1);

    // digest drain
    if (dig_o.valid && dig_o.ready) begin
      if (oidx_q == 2'd3) begin
        obusy_d = 1'b0;
        oidx_d  = 2'd0;
      end else begin
        oidx_d = oidx_q + 2'd1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (req_i.mode == ModeAbsorb) begin
            mem_we   = 1'b1;
            fill_d   = fill_q + 6'd1;
            bitlen_d = bitlen_q + 64'd8;
            if (fill_q == 6'(BlockBytes - 1)) begin
              state_d = S_LOAD;
            end
          end else begin
            fin_d    = 1'b1;
            first_d  = 1'b1;
            lenblk_d = (fill_q < 6'(LenPos));
            state_d  = S_PAD;
          end
        end
      end
      S_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = pad_byte;
        first_d   = 1'b0;
        fill_d    = fill_q + 6'd1;
        if (fill_q == 6'(BlockBytes - 1)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        mem_raddr = msg_index(6'd0);
        rw_d      = chain_q;
        rnd_d     = 6'd0;
        state_d   = S_ROUND;
      end
      S_ROUND: begin
        rw_d  = round_nxt;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        chain_d.a = chain_q.a + rw_q.a;
        chain_d.b = chain_q.b + rw_q.b;
        chain_d.c = chain_q.c + rw_q.c;
        chain_d.d = chain_q.d + rw_q.d;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (lenblk_q) begin
          state_d = S_DONE;
        end else begin
          lenblk_d = 1'b1;
          state_d  = S_PAD;
        end
      end
      S_DONE: begin
        if (!obusy_q) begin
          obuf_d   = {chain_q.d, chain_q.c, chain_q.b, chain_q.a};
          obusy_d  = 1'b1;
          oidx_d   = 2'd0;
          chain_d  = InitChain;
          bitlen_d = '0;
          fin_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      bitlen_q <= '0;
      chain_q  <= InitChain;
      rw_q     <= '0;
      rnd_q    <= '0;
      first_q  <= 1'b0;
      lenblk_q <= 1'b0;
      fin_q    <= 1'b0;
      oidx_q   <= '0;
      obusy_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      bitlen_q <= bitlen_d;
      chain_q  <= chain_d;
      rw_q     <= rw_d;
      rnd_q    <= rnd_d;
      first_q  <= first_d;
      lenblk_q <= lenblk_d;
      fin_q    <= fin_d;
      oidx_q   <= oidx_d;
      obusy_q  <= obusy_d;
    end
  end

  // digest buffer payload
  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  assign dig_o.valid       = obusy_q;
  assign dig_o.digest_word = obuf_q[oidx_q];
  assign dig_o.word_index  = oidx_q;
  assign dig_o.last        = (oidx_q == 2'd3);

  // compression always starts on an empty fill position
  a_load_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> fill_q == 6'd0)
    else $error("compression started with partial block");

  // last round hands over to the chaining add
  a_round_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND && rnd_q == 6'd63 |=> state_q == S_ADD)
    else $error("round count overran");

  // a full pad block goes on to compression
  a_pad_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD && fill_q == 6'd63 |=> state_q == S_LOAD)
    else $error("pad block not compressed");

  // digest hand-off restarts the message
  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !obusy_q |=>
      obusy_q && chain_q == InitChain && bitlen_q == 64'd0 && oidx_q == 2'd0)
    else $error("digest hand-off did not restart message");

endmodule
